/* sv/lars_pkg.sv */
// ----------------------------------------------------------------------------
// lars_pkg: shared types and constants for the life row step unit
// Board limits, config register codes, the per-column link bundle passed
// between neighboring cells, and the result beat layout.
// ----------------------------------------------------------------------------
package lars_pkg;

  // board geometry
  localparam int MAX_COLS   = 64;
  localparam int MAX_ROWS   = 4096;
  localparam int COL_W      = 7;   // holds 0..MAX_COLS
  localparam int ROW_W      = 12;  // row index
  localparam int ROWS_CFG_W = 13;  // board_rows register
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // reset values of the config registers
  localparam logic [ROWS_CFG_W-1:0] ROWS_RST = ROWS_CFG_W'(40);
  localparam logic [COL_W-1:0]      COLS_RST = COL_W'(64);

  // config register codes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOARD_ROWS = 2'd0,
    REG_BOARD_COLS = 2'd1
  } cfg_reg_t;

  // bits one column shares with its neighbors
  typedef struct packed {
    logic up;    // row r-2
    logic mid;   // row r-1
    logic cur;   // incoming row r, masked
  } col_link_t;

  // per-cycle control to every cell
  typedef struct packed {
    logic adv;   // a row beat is accepted
    logic clr;   // that row closes the frame
  } cell_ctl_t;

  // one result beat
  typedef struct packed {
    logic [MAX_COLS-1:0] cells;
    logic [ROW_W-1:0]    row;
    logic                done;
  } res_beat_t;

endpackage

/* sv/lars_cell.sv */
// ----------------------------------------------------------------------------
// lars_cell: one board column of the life row step unit
// Holds the column's bits of the two previous rows and computes the next
// state of row r-1 (with row r below) and of row r (with a dead row below).
// ----------------------------------------------------------------------------
module lars_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                col_en,
  input  logic                in_bit,
  input  lars_pkg::cell_ctl_t ctl,
  input  lars_pkg::col_link_t left,
  input  lars_pkg::col_link_t right,
  output lars_pkg::col_link_t self,
  output logic                nxt_mid,
  output logic                nxt_cur
);

  logic       up_r, up_nxt;
  logic       mid_r, mid_nxt;
  logic       cur;
  logic [3:0] cnt_mid;
  logic [3:0] cnt_cur;

  // columns beyond the width are dead
  assign cur = in_bit & col_en;

  assign self.up  = up_r;
  assign self.mid = mid_r;
  assign self.cur = cur;

  // neighbor counts for the middle row and for the incoming row
  assign cnt_mid = 4'(left.up) + 4'(up_r) + 4'(right.up)
                 + 4'(left.mid) + 4'(right.mid)
                 + 4'(left.cur) + 4'(cur) + 4'(right.cur);
  assign cnt_cur = 4'(left.mid) + 4'(mid_r) + 4'(right.mid)
                 + 4'(left.cur) + 4'(right.cur);

  // b3/s23 rule, masked to the width
  assign nxt_mid = col_en & ((cnt_mid == 4'd3) | ((cnt_mid == 4'd2) & mid_r));
  assign nxt_cur = col_en & ((cnt_cur == 4'd3) | ((cnt_cur == 4'd2) & cur));

  // shift rows down, drop both at the end of a frame
  always_comb begin
    up_nxt  = up_r;
    mid_nxt = mid_r;
    if (ctl.adv) begin
      if (ctl.clr) begin
        up_nxt  = 1'b0;
        mid_nxt = 1'b0;
      end else begin
        up_nxt  = mid_r;
        mid_nxt = cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r  <= 1'b0;
      mid_r <= 1'b0;
    end else begin
      up_r  <= up_nxt;
      mid_r <= mid_nxt;
    end
  end

endmodule

/* sv/life_automaton_row_step_unit.sv */
// ----------------------------------------------------------------------------
// life_automaton_row_step_unit: streaming life generation, one row a beat
// Column cells keep the two previous rows; each input beat but a frame's
// first yields the next state of the row above, and the last also its own.
// ----------------------------------------------------------------------------
//
//   channel | direction | beat
//   --------+-----------+-----------------------------------------------
//   in_     | input     | row_cells, one board row
//   out_    | output    | next_row_cells, row_number, frame_done
//   cfg_    | input     | cfg_index, cfg_data (board_rows, board_cols)
//
// One row beat is taken per cycle while in_ready is high; all 64 columns
// count their neighbors in the same cycle. Results are registered in a
// three-entry queue. A frame's last row pushes two results unless it is
// also its first; in_ready then drops until a result leaves, even with
// no output stall. in_ready comes from registers only: high while at most
// one result waits. Reset clears stored rows, the row counter and the
// queue; cfg_ready is always high.
module life_automaton_row_step_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lars_pkg::MAX_COLS-1:0]       in_row_cells,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lars_pkg::MAX_COLS-1:0]       out_next_row_cells,
  output logic [lars_pkg::ROW_W-1:0]          out_row_number,
  output logic                                out_frame_done,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lars_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lars_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int QD = 3;

  logic [lars_pkg::ROWS_CFG_W-1:0] rows_cfg_r;
  logic [lars_pkg::COL_W-1:0]      cols_cfg_r;
  logic [lars_pkg::ROW_W-1:0]      row_cnt_r, row_cnt_nxt;
  logic [lars_pkg::ROWS_CFG_W-1:0] eff_rows;
  logic [lars_pkg::COL_W-1:0]      eff_cols;
  logic [lars_pkg::ROW_W-1:0]      last_row;
  logic                            acc;
  logic                            is_last;
  logic                            push_a;
  logic                            push_b;
  logic                            pop;
  lars_pkg::cell_ctl_t             ctl;
  lars_pkg::col_link_t             links [lars_pkg::MAX_COLS];
  logic [lars_pkg::MAX_COLS-1:0]   nxt_mid;
  logic [lars_pkg::MAX_COLS-1:0]   nxt_cur;
  lars_pkg::res_beat_t             res_a;
  lars_pkg::res_beat_t             res_b;
  lars_pkg::res_beat_t             q_r   [QD];
  lars_pkg::res_beat_t             q_nxt [QD];
  logic [1:0]                      cnt_r, cnt_nxt;
  logic [1:0]                      base;
  logic [1:0]                      slot_b;

  // config writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= lars_pkg::ROWS_RST;
      cols_cfg_r <= lars_pkg::COLS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lars_pkg::REG_BOARD_ROWS: rows_cfg_r <= cfg_data;
        lars_pkg::REG_BOARD_COLS: cols_cfg_r <= cfg_data[lars_pkg::COL_W-1:0];
        default: ;
      endcase
    end
  end

  // effective height and width, clamped to the board limits
  always_comb begin
    eff_rows = rows_cfg_r;
    if (rows_cfg_r == '0)
      eff_rows = lars_pkg::ROWS_CFG_W'(1);
    else if (rows_cfg_r > lars_pkg::ROWS_CFG_W'(lars_pkg::MAX_ROWS))
      eff_rows = lars_pkg::ROWS_CFG_W'(lars_pkg::MAX_ROWS);
    eff_cols = cols_cfg_r;
    if (cols_cfg_r == '0)
      eff_cols = lars_pkg::COL_W'(1);
    else if (cols_cfg_r > lars_pkg::COL_W'(lars_pkg::MAX_COLS))
      eff_cols = lars_pkg::COL_W'(lars_pkg::MAX_COLS);
  end

  assign last_row = lars_pkg::ROW_W'(eff_rows - lars_pkg::ROWS_CFG_W'(1));

  // input handshake and row counter
  assign in_ready = (cnt_r <= 2'd1);
  assign acc      = in_valid & in_ready;
  assign is_last  = (row_cnt_r >= last_row);
  assign ctl.adv  = acc;
  assign ctl.clr  = is_last;

  always_comb begin
    row_cnt_nxt = row_cnt_r;
    if (acc)
      row_cnt_nxt = is_last ? '0 : row_cnt_r + lars_pkg::ROW_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) row_cnt_r <= '0;
    else        row_cnt_r <= row_cnt_nxt;
  end

  // chain of column cells, edges see dead neighbors
  for (genvar c = 0; c < lars_pkg::MAX_COLS; c++) begin : g_col
    lars_pkg::col_link_t lnb, rnb;
    logic                en;

    if (c == 0) begin : g_le
      assign lnb = '0;
    end else begin : g_li
      assign lnb = links[c-1];
    end
    if (c == lars_pkg::MAX_COLS - 1) begin : g_re
      assign rnb = '0;
    end else begin : g_ri
      assign rnb = links[c+1];
    end
    assign en = (lars_pkg::COL_W'(c) < eff_cols);

    lars_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .col_en  (en),
      .in_bit  (in_row_cells[c]),
      .ctl     (ctl),
      .left    (lnb),
      .right   (rnb),
      .self    (links[c]),
      .nxt_mid (nxt_mid[c]),
      .nxt_cur (nxt_cur[c])
    );
  end

  // results of this beat
  assign push_a     = acc & (row_cnt_r != '0);
  assign push_b     = acc & is_last;
  assign res_a.cells = nxt_mid;
  assign res_a.row   = row_cnt_r - lars_pkg::ROW_W'(1);
  assign res_a.done  = 1'b0;
  assign res_b.cells = nxt_cur;
  assign res_b.row   = row_cnt_r;
  assign res_b.done  = 1'b1;

  // result queue, head at entry 0
  assign pop    = out_valid & out_ready;
  assign base   = cnt_r - {1'b0, pop};
  assign slot_b = base + {1'b0, push_a};

  always_comb begin
    for (int i = 0; i < QD; i++) begin
      q_nxt[i] = q_r[i];
      if (pop && i < QD - 1) q_nxt[i] = q_r[(i + 1) % QD];
      if (push_a && base == 2'(i)) q_nxt[i] = res_a;
      if (push_b && slot_b == 2'(i)) q_nxt[i] = res_b;
    end
    cnt_nxt = slot_b + {1'b0, push_b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QD; i++) q_r[i] <= q_nxt[i];
  end

  // output beat
  assign out_valid          = (cnt_r != '0);
  assign out_next_row_cells = q_r[0].cells;
  assign out_row_number     = q_r[0].row;
  assign out_frame_done     = q_r[0].done;

endmodule

/* dv/life_automaton_row_step_unit_tb.sv */
// ----------------------------------------------------------------------------
// life_automaton_row_step_unit_tb: self-checking bench for the life row step
// Streams board rows through the unit under varied board geometry and
// handshake pressure, predicts every next-generation row beat, and checks
// each result beat in order against the predicted rows.
// ----------------------------------------------------------------------------
module life_automaton_row_step_unit_tb;

  localparam int DRAIN_CYCLES   = 8;
  localparam int END_CYCLES     = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ROWS    = 370;
  localparam int LONG_ROWS      = 100;
  localparam int OVER_ROWS      = 50;

  // register indexes past the end of the register map
  localparam logic [lars_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [lars_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [lars_pkg::MAX_COLS-1:0]   in_row_cells = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [lars_pkg::MAX_COLS-1:0]   out_next_row_cells;
  logic [lars_pkg::ROW_W-1:0]      out_row_number;
  logic                            out_frame_done;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [lars_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [lars_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int error_count   = 0;
  int quiet_cycles  = 0;

  // board model: geometry registers, two stored rows, next row index
  logic [lars_pkg::ROWS_CFG_W-1:0] board_rows_q;
  logic [lars_pkg::COL_W-1:0]      board_cols_q;
  logic [lars_pkg::MAX_COLS-1:0]   upper_q;
  logic [lars_pkg::MAX_COLS-1:0]   middle_q;
  logic [lars_pkg::ROW_W-1:0]      next_row_q;
  lars_pkg::res_beat_t             rows_due[$];

  life_automaton_row_step_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_row_cells       (in_row_cells),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_next_row_cells (out_next_row_cells),
    .out_row_number     (out_row_number),
    .out_frame_done     (out_frame_done),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #5 clk = ~clk;

  // live columns of a row for a given width register
  function automatic logic [lars_pkg::MAX_COLS-1:0] live_columns(
      input logic [lars_pkg::COL_W-1:0] cols);
    int w;
    w = (cols == 0) ? 1 :
        ((cols > lars_pkg::MAX_COLS) ? lars_pkg::MAX_COLS : int'(cols));
    if (w >= 64) return '1;
    return (64'd1 << w) - 64'd1;
  endfunction

  // rows per frame for a given height register
  function automatic int frame_height(input logic [lars_pkg::ROWS_CFG_W-1:0] rows);
    if (rows == 0) return 1;
    if (rows > lars_pkg::MAX_ROWS) return lars_pkg::MAX_ROWS;
    return int'(rows);
  endfunction

  // b3/s23 rule for the middle row, cells off the board are dead
  function automatic logic [lars_pkg::MAX_COLS-1:0] life_rule(
      input logic [lars_pkg::MAX_COLS-1:0] up,
      input logic [lars_pkg::MAX_COLS-1:0] mid,
      input logic [lars_pkg::MAX_COLS-1:0] low,
      input logic [lars_pkg::MAX_COLS-1:0] mask);
    logic [lars_pkg::MAX_COLS+1:0] u;
    logic [lars_pkg::MAX_COLS+1:0] m;
    logic [lars_pkg::MAX_COLS+1:0] l;
    logic [lars_pkg::MAX_COLS-1:0] res;
    int n;
    u = {1'b0, up, 1'b0};
    m = {1'b0, mid, 1'b0};
    l = {1'b0, low, 1'b0};
    res = '0;
    for (int c = 0; c < lars_pkg::MAX_COLS; c++) begin
      n = int'(u[c]) + int'(u[c+1]) + int'(u[c+2]) + int'(m[c]) + int'(m[c+2])
        + int'(l[c]) + int'(l[c+1]) + int'(l[c+2]);
      res[c] = (n == 3) || (n == 2 && mid[c]);
    end
    return res & mask;
  endfunction

  // track config beats, predict row beats, check result beats
  always @(posedge clk) begin : board_monitor
    logic [lars_pkg::MAX_COLS-1:0] cur;
    logic [lars_pkg::MAX_COLS-1:0] mask;
    int                            last;
    lars_pkg::res_beat_t           got;
    lars_pkg::res_beat_t           want;
    if (!rst_n) begin
      board_rows_q = lars_pkg::ROWS_RST;
      board_cols_q = lars_pkg::COLS_RST;
      upper_q      = '0;
      middle_q     = '0;
      next_row_q   = '0;
      rows_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lars_pkg::REG_BOARD_ROWS: board_rows_q = cfg_data;
          lars_pkg::REG_BOARD_COLS: board_cols_q = cfg_data[lars_pkg::COL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        mask = live_columns(board_cols_q);
        cur  = in_row_cells & mask;
        last = frame_height(board_rows_q) - 1;
        if (next_row_q == 0) begin
          upper_q  = '0;
          middle_q = '0;
        end else begin
          rows_due.push_back('{life_rule(upper_q, middle_q, cur, mask),
                               lars_pkg::ROW_W'(next_row_q - 1), 1'b0});
        end
        if (int'(next_row_q) >= last) begin
          rows_due.push_back('{life_rule(middle_q, cur, '0, mask), next_row_q, 1'b1});
          upper_q    = '0;
          middle_q   = '0;
          next_row_q = '0;
        end else begin
          upper_q    = middle_q;
          middle_q   = cur;
          next_row_q = next_row_q + 1'b1;
        end
      end
      if (out_valid && out_ready) begin
        got = '{out_next_row_cells, out_row_number, out_frame_done};
        if (rows_due.size() == 0) begin
          $error("result beat with no row due: row_number %0d", got.row);
          error_count++;
        end else begin
          want = rows_due.pop_front();
          if (got.cells !== want.cells) begin
            $error("next_row_cells: expected %h, actual %h", want.cells, got.cells);
            error_count++;
          end
          if (got.row !== want.row) begin
            $error("row_number: expected %0d, actual %0d", want.row, got.row);
            error_count++;
          end
          if (got.done !== want.done) begin
            $error("frame_done: expected %0b, actual %0b", want.done, got.done);
            error_count++;
          end
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one row beat; valid stays up after acceptance for a back-to-back row
  task automatic send_row(input logic [lars_pkg::MAX_COLS-1:0] cells);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_row_cells <= cells;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop sending and let every due row come out
  task automatic drain_rows();
    in_valid <= 1'b0;
    do @(negedge clk); while (rows_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lars_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lars_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_board(input logic [lars_pkg::CFG_DATA_W-1:0] rows,
                           input logic [lars_pkg::CFG_DATA_W-1:0] cols);
    drain_rows();
    write_reg(lars_pkg::REG_BOARD_ROWS, rows);
    write_reg(lars_pkg::REG_BOARD_COLS, cols);
    cfg_valid <= 1'b0;
  endtask

  task automatic poke_spare(input logic [lars_pkg::CFG_IDX_W-1:0] idx,
                            input logic [lars_pkg::CFG_DATA_W-1:0] data);
    drain_rows();
    write_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  // row patterns from empty through sparse and dense to full
  function automatic logic [lars_pkg::MAX_COLS-1:0] random_row();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return {$urandom & $urandom, $urandom & $urandom};
      2: return {$urandom | $urandom, $urandom | $urandom};
      3: return '0;
      4: return '1;
      default: return {$urandom & $urandom & $urandom, $urandom};
    endcase
  endfunction

  function automatic logic [lars_pkg::CFG_DATA_W-1:0] random_height();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 13'd1;
      2: return lars_pkg::CFG_DATA_W'($urandom);
      3: return '1;
      default: return lars_pkg::CFG_DATA_W'($urandom_range(2, 12));
    endcase
  endfunction

  // width with random bits above the register field
  function automatic logic [lars_pkg::CFG_DATA_W-1:0] random_width();
    logic [lars_pkg::CFG_DATA_W-lars_pkg::COL_W-1:0] junk;
    junk = ($urandom_range(0, 1) == 0) ? '0 :
           (lars_pkg::CFG_DATA_W-lars_pkg::COL_W)'($urandom);
    case ($urandom_range(0, 7))
      0: return {junk, 7'd0};
      1: return {junk, 7'd1};
      2: return {junk, 7'd64};
      3: return lars_pkg::CFG_DATA_W'($urandom);
      default: return {junk, lars_pkg::COL_W'($urandom_range(1, 64))};
    endcase
  endfunction

  // reset geometry, then a height cut below the rows already in
  task automatic test_default_geometry();
    send_row('1);
    send_row('0);
    send_row(64'hAAAA_AAAA_AAAA_AAAA);
    set_board(13'd2, 13'd64);
    send_row(64'h5555_5555_5555_5555);
  endtask

  // zero height and zero width, then an exact one-row frame
  task automatic test_single_row_frames();
    set_board(13'd0, 13'd0);
    send_row('1);
    send_row(64'h1);
    set_board(13'd1, 13'd64);
    send_row(64'h8000_0000_0000_0001);
  endtask

  // width saturation with high data bits, then the narrowest board
  task automatic test_width_limits();
    set_board(13'd3, 13'h1FC1);
    send_row('0);
    send_row(64'hE000_0000_0000_0007);
    send_row('0);
    set_board(13'd3, 13'd1);
    send_row('1);
    send_row('1);
    send_row('1);
  endtask

  // stored rows keep the old width, results take the new one
  task automatic test_width_change_mid_frame();
    set_board(13'd4, 13'd64);
    send_row(random_row());
    send_row('1);
    set_board(13'd4, 13'd5);
    send_row('1);
    send_row('1);
  endtask

  // writes past the register map must not disturb anything
  task automatic test_spare_registers();
    poke_spare(REG_SPARE_2, '1);
    poke_spare(REG_SPARE_3, '0);
    send_row(64'h0000_0001_8000_0000);
    send_row(64'h0000_0003_C000_0000);
  endtask

  // full height written, then cut well below the current row
  task automatic test_height_cut_past_end();
    set_board(13'h1000, 13'd64);
    send_row(random_row());
    send_row(random_row());
    send_row(random_row());
    set_board(13'd2, 13'd64);
    send_row(random_row());
  endtask

  // random rows with geometry changes landing anywhere in a frame
  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    int sent;
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    sent = 0;
    while (sent < RANDOM_ROWS) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 7) == 0)
          poke_spare(($urandom_range(0, 1) == 0) ? REG_SPARE_2 : REG_SPARE_3,
                     lars_pkg::CFG_DATA_W'($urandom));
        else
          set_board(random_height(), random_width());
      end
      send_row(random_row());
      sent++;
    end
    drain_rows();
  endtask

  // oversized heights saturate, so long frames run on until a height cut
  task automatic test_oversized_height();
    in_idle_pct   = 10;
    out_stall_pct = 10;
    set_board('1, 13'd64);
    for (int i = 0; i < LONG_ROWS; i++) send_row(random_row());
    set_board(13'h1001, 13'd64);
    for (int i = 0; i < OVER_ROWS; i++) send_row(random_row());
    set_board(13'd2, 13'd64);
    send_row(random_row());
    drain_rows();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_geometry();
    test_single_row_frames();
    test_width_limits();
    test_width_change_mid_frame();
    test_spare_registers();
    test_height_cut_past_end();
    test_random_traffic(0, 0);
    test_random_traffic(60, 0);
    test_random_traffic(0, 60);
    test_random_traffic(30, 30);
    test_oversized_height();
    in_valid <= 1'b0;
    do @(negedge clk); while (rows_due.size() != 0);
    repeat (END_CYCLES) @(posedge clk);
    if (rows_due.size() != 0) begin
      $error("%0d expected result beats never came", rows_due.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
